// ----- design/spm_pkg.sv -----
// shared constants and types for the segment plane mask sampler
package spm_pkg;

    // command codes carried on cmd
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // configuration register indexes, one 8-byte slot each
    typedef enum logic [2:0] {
        REG_ROW_X       = 3'd0,
        REG_ROW_Y       = 3'd1,
        REG_ROW_Z       = 3'd2,
        REG_OFFSET_X    = 3'd3,
        REG_OFFSET_Y    = 3'd4,
        REG_OFFSET_Z    = 3'd5,
        REG_MASK_WIDTH  = 3'd6,
        REG_MASK_HEIGHT = 3'd7
    } reg_idx_t;

    // fixed point layout
    localparam int COEF_W    = 16;    // Q4.12 matrix coefficient
    localparam int COEF_FRAC = 12;
    localparam int U_BITS    = 30;    // crossing fraction, Q0.30

    // reset values of the configuration
    localparam logic [47:0] ROW_X_RESET = 48'h0000_0000_1000;
    localparam logic [47:0] ROW_Y_RESET = 48'h0000_1000_0000;
    localparam logic [47:0] ROW_Z_RESET = 48'h1000_0000_0000;
    localparam logic [8:0]  SIZE_RESET  = 9'd256;

    // divide by three as multiply by 683 and shift by 11, exact below 768
    localparam logic [9:0] LUM_RECIP = 10'd683;
    localparam int         LUM_SHIFT = 11;

endpackage

// ----- design/segment_plane_mask_sampler_top.sv -----
// top level of the segment plane mask sampler: transform, divide, sample
//
// channel   direction  handshake                  payload
// command   in         start high, busy low       cmd, texel_index, red, green, blue,
//                                                 single_channel, src_*, dst_*
// result    out        done strobe, one cycle     mask_value
// config    in/out     apb write/read, 64-bit     row_x..mask_height at 8*index
//
// one beat enters every cycle; busy is never raised
// a sample beat passes the transform stages, the 30-stage crossing divider, then the
// texel fetch and blend stages before its result appears on mask_value with done
// a texel write lands in the mask at the fetch stage, so later samples see it
// reset clears pipeline valids and config; the mask holds no reset value
// the receiver cannot stall, so the pipeline never holds
module segment_plane_mask_sampler_top #(
    parameter int MAX_SIDE = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    // command channel
    input  logic               start,
    output logic               busy,
    input  logic               cmd,
    input  logic [15:0]        texel_index,
    input  logic [7:0]         red,
    input  logic [7:0]         green,
    input  logic [7:0]         blue,
    input  logic               single_channel,
    input  logic signed [31:0] src_x,
    input  logic signed [31:0] src_y,
    input  logic signed [31:0] src_z,
    input  logic signed [31:0] dst_x,
    input  logic signed [31:0] dst_y,
    input  logic signed [31:0] dst_z,
    // result channel
    output logic               done,
    output logic [15:0]        mask_value,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int XW    = $clog2(MAX_SIDE);
    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int QW    = spm_pkg::U_BITS;
    localparam int LAT   = 12 + QW;

    localparam logic signed [49:0] SAT_MAX = 50'sd2147483647;
    localparam logic signed [49:0] SAT_MIN = -50'sd2147483648;

    typedef struct packed {
        logic          smp;
        logic          wen;
        logic [AW-1:0] waddr;
        logic [7:0]    lum;
    } ctl_t;

    typedef struct packed {
        ctl_t               ctl;
        logic               hit;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [32:0] ddx;
        logic signed [32:0] ddy;
    } seg_t;

    // floor shift by the coefficient fraction, then clamp to Q16.16
    function automatic logic signed [31:0] sat32(input logic signed [49:0] a);
        logic signed [49:0] sh;
        sh = a >>> spm_pkg::COEF_FRAC;
        if (sh > SAT_MAX)
            return 32'sh7FFF_FFFF;
        else if (sh < SAT_MIN)
            return 32'sh8000_0000;
        else
            return 32'(sh);
    endfunction

    // ---------------- configuration ----------------
    logic [47:0]        row_x_reg, row_y_reg, row_z_reg;
    logic signed [31:0] offset_x_reg, offset_y_reg, offset_z_reg;
    logic [8:0]         mask_width_reg, mask_height_reg;
    logic               cfg_wr;
    spm_pkg::reg_idx_t  cfg_idx;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = spm_pkg::reg_idx_t'(paddr[5:3]);

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_x_reg       <= spm_pkg::ROW_X_RESET;
            row_y_reg       <= spm_pkg::ROW_Y_RESET;
            row_z_reg       <= spm_pkg::ROW_Z_RESET;
            offset_x_reg    <= '0;
            offset_y_reg    <= '0;
            offset_z_reg    <= '0;
            mask_width_reg  <= spm_pkg::SIZE_RESET;
            mask_height_reg <= spm_pkg::SIZE_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                spm_pkg::REG_ROW_X:       row_x_reg       <= pwdata[47:0];
                spm_pkg::REG_ROW_Y:       row_y_reg       <= pwdata[47:0];
                spm_pkg::REG_ROW_Z:       row_z_reg       <= pwdata[47:0];
                spm_pkg::REG_OFFSET_X:    offset_x_reg    <= pwdata[31:0];
                spm_pkg::REG_OFFSET_Y:    offset_y_reg    <= pwdata[31:0];
                spm_pkg::REG_OFFSET_Z:    offset_z_reg    <= pwdata[31:0];
                spm_pkg::REG_MASK_WIDTH:  mask_width_reg  <= pwdata[8:0];
                spm_pkg::REG_MASK_HEIGHT: mask_height_reg <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    // register read
    always_comb
    begin
        unique case (cfg_idx)
            spm_pkg::REG_ROW_X:       prdata = 64'(row_x_reg);
            spm_pkg::REG_ROW_Y:       prdata = 64'(row_y_reg);
            spm_pkg::REG_ROW_Z:       prdata = 64'(row_z_reg);
            spm_pkg::REG_OFFSET_X:    prdata = 64'(unsigned'(offset_x_reg));
            spm_pkg::REG_OFFSET_Y:    prdata = 64'(unsigned'(offset_y_reg));
            spm_pkg::REG_OFFSET_Z:    prdata = 64'(unsigned'(offset_z_reg));
            spm_pkg::REG_MASK_WIDTH:  prdata = 64'(mask_width_reg);
            spm_pkg::REG_MASK_HEIGHT: prdata = 64'(mask_height_reg);
            default:                  prdata = '0;
        endcase
    end

    // effective mask size, clamped to 1..MAX_SIDE
    logic [31:0]   wsel, hsel;
    logic [SW-1:0] eff_w;
    logic [XW-1:0] wm1, hm1;

    always_comb
    begin
        if (mask_width_reg == '0)
            wsel = 32'd1;
        else if (32'(mask_width_reg) > 32'(MAX_SIDE))
            wsel = 32'(MAX_SIDE);
        else
            wsel = 32'(mask_width_reg);
        if (mask_height_reg == '0)
            hsel = 32'd1;
        else if (32'(mask_height_reg) > 32'(MAX_SIDE))
            hsel = 32'(MAX_SIDE);
        else
            hsel = 32'(mask_height_reg);
    end

    assign eff_w = SW'(wsel);
    assign wm1   = XW'(wsel - 32'd1);
    assign hm1   = XW'(hsel - 32'd1);

    // ---------------- stage 1: products and luminance ----------------
    logic [47:0]        rows [3];
    logic signed [31:0] offs [3];
    logic signed [31:0] src_c [3];
    logic signed [31:0] dst_c [3];
    logic [9:0]         rgb_sum;
    logic [19:0]        lum_prod;
    ctl_t               ctl_in;

    assign rows  = '{row_x_reg, row_y_reg, row_z_reg};
    assign offs  = '{offset_x_reg, offset_y_reg, offset_z_reg};
    assign src_c = '{src_x, src_y, src_z};
    assign dst_c = '{dst_x, dst_y, dst_z};

    assign rgb_sum  = 10'(red) + 10'(green) + 10'(blue);
    assign lum_prod = 20'(rgb_sum) * 20'(spm_pkg::LUM_RECIP);

    always_comb
    begin
        ctl_in.smp   = (cmd == spm_pkg::CMD_SAMPLE);
        ctl_in.wen   = (cmd == spm_pkg::CMD_WRITE) && (32'(texel_index) < 32'(DEPTH));
        ctl_in.waddr = AW'(texel_index);
        ctl_in.lum   = single_channel ? red : lum_prod[spm_pkg::LUM_SHIFT +: 8];
    end

    logic               v1_reg;
    ctl_t               ctl1_reg;
    logic signed [47:0] ps_reg [3][3];
    logic signed [47:0] pd_reg [3][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= start & ~busy;
    end

    always_ff @(posedge clk)
    begin
        ctl1_reg <= ctl_in;
        for (int j = 0; j < 3; j++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ps_reg[j][k] <= $signed(rows[j][spm_pkg::COEF_W*k +: spm_pkg::COEF_W])
                                * src_c[k];
                pd_reg[j][k] <= $signed(rows[j][spm_pkg::COEF_W*k +: spm_pkg::COEF_W])
                                * dst_c[k];
            end
        end
    end

    // ---------------- stage 2: row sums plus offset ----------------
    logic               v2_reg;
    ctl_t               ctl2_reg;
    logic signed [49:0] as_reg [3];
    logic signed [49:0] ad_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        ctl2_reg <= ctl1_reg;
        for (int j = 0; j < 3; j++)
        begin
            as_reg[j] <= 50'(ps_reg[j][0]) + 50'(ps_reg[j][1]) + 50'(ps_reg[j][2])
                         + (50'(offs[j]) <<< spm_pkg::COEF_FRAC);
            ad_reg[j] <= 50'(pd_reg[j][0]) + 50'(pd_reg[j][1]) + 50'(pd_reg[j][2])
                         + (50'(offs[j]) <<< spm_pkg::COEF_FRAC);
        end
    end

    // ---------------- stage 3: scale and saturate ----------------
    logic               v3_reg;
    ctl_t               ctl3_reg;
    logic signed [31:0] cs_reg [3];
    logic signed [31:0] cd_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        ctl3_reg <= ctl2_reg;
        for (int j = 0; j < 3; j++)
        begin
            cs_reg[j] <= sat32(as_reg[j]);
            cd_reg[j] <= sat32(ad_reg[j]);
        end
    end

    // ---------------- stage 4: plane test and divider operands ----------------
    logic        straddle;
    logic [32:0] neg_a, neg_b;
    logic [31:0] mag_a, mag_b;
    seg_t        seg_in;

    assign straddle = (cs_reg[2] > 32'sd0 && cd_reg[2] < 32'sd0)
                   || (cs_reg[2] < 32'sd0 && cd_reg[2] > 32'sd0);
    assign neg_a    = -33'(cs_reg[2]);
    assign neg_b    = -33'(cd_reg[2]);
    assign mag_a    = cs_reg[2][31] ? neg_a[31:0] : unsigned'(cs_reg[2]);
    assign mag_b    = cd_reg[2][31] ? neg_b[31:0] : unsigned'(cd_reg[2]);

    always_comb
    begin
        seg_in.ctl = ctl3_reg;
        seg_in.hit = straddle;
        seg_in.ax  = cs_reg[0];
        seg_in.ay  = cs_reg[1];
        seg_in.ddx = 33'(cd_reg[0]) - 33'(cs_reg[0]);
        seg_in.ddy = 33'(cd_reg[1]) - 33'(cs_reg[1]);
    end

    logic        v4_reg;
    seg_t        seg4_reg;
    logic [31:0] num4_reg;
    logic [32:0] den4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        seg4_reg <= seg_in;
        num4_reg <= mag_a;
        den4_reg <= {1'b0, mag_a} + {1'b0, mag_b};
    end

    // ---------------- crossing fraction divider ----------------
    logic                  dv_valid;
    logic [QW-1:0]         dv_quo;
    logic [$bits(seg_t)-1:0] dv_tag;
    seg_t                  dv_seg;

    spm_div #(
        .NW (32),
        .QW (QW),
        .TW ($bits(seg_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .in_num    (num4_reg),
        .in_den    (den4_reg),
        .in_tag    (seg4_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_tag   (dv_tag)
    );

    assign dv_seg = seg_t'(dv_tag);

    // ---------------- stage 5: delta times fraction ----------------
    logic               v5_reg;
    ctl_t               ctl5_reg;
    logic               hit5_reg;
    logic signed [31:0] ax5_reg, ay5_reg;
    logic signed [63:0] mx5_reg, my5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else
            v5_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        ctl5_reg <= dv_seg.ctl;
        hit5_reg <= dv_seg.hit;
        ax5_reg  <= dv_seg.ax;
        ay5_reg  <= dv_seg.ay;
        mx5_reg  <= dv_seg.ddx * $signed({1'b0, dv_quo});
        my5_reg  <= dv_seg.ddy * $signed({1'b0, dv_quo});
    end

    // ---------------- stage 6: crossing point and bounds ----------------
    logic signed [63:0] shx, shy;
    logic signed [33:0] px, py;
    logic               inb;

    assign shx = mx5_reg >>> QW;
    assign shy = my5_reg >>> QW;
    assign px  = 34'(ax5_reg) + 34'(shx);
    assign py  = 34'(ay5_reg) + 34'(shy);
    assign inb = (px >= -34'sd32768) && (px < 34'sd32768)
              && (py >= -34'sd32768) && (py < 34'sd32768);

    logic        v6_reg;
    ctl_t        ctl6_reg;
    logic        ok6_reg;
    logic [15:0] ux6_reg, uy6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else
            v6_reg <= v5_reg;
    end

    always_ff @(posedge clk)
    begin
        ctl6_reg <= ctl5_reg;
        ok6_reg  <= hit5_reg & inb;
        ux6_reg  <= 16'(px + 34'sd32768);
        uy6_reg  <= 16'(py + 34'sd32768);
    end

    // ---------------- stage 7: scale to texel space ----------------
    logic             v7_reg;
    ctl_t             ctl7_reg;
    logic             ok7_reg;
    logic [16+XW-1:0] qx7_reg, qy7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v7_reg <= 1'b0;
        else
            v7_reg <= v6_reg;
    end

    always_ff @(posedge clk)
    begin
        ctl7_reg <= ctl6_reg;
        ok7_reg  <= ok6_reg;
        qx7_reg  <= (16+XW)'(ux6_reg) * (16+XW)'(wm1);
        qy7_reg  <= (16+XW)'(uy6_reg) * (16+XW)'(hm1);
    end

    // ---------------- stage 8: neighbour clamp ----------------
    logic [XW-1:0] x1, y1;
    logic [31:0]   xn, yn;
    logic [XW-1:0] xc1, yc1;

    assign x1 = qx7_reg[16 +: XW];
    assign y1 = qy7_reg[16 +: XW];
    assign xn = 32'(x1) + 32'd1;
    assign yn = 32'(y1) + 32'd1;

    always_comb
    begin
        xc1 = (xn >= wsel) ? wm1 : XW'(xn);
        yc1 = (yn >= hsel) ? hm1 : XW'(yn);
    end

    logic          v8_reg;
    ctl_t          ctl8_reg;
    logic          ok8_reg;
    logic [XW-1:0] cx0_reg, cx1_reg, cy0_reg, cy1_reg;
    logic [15:0]   fx8_reg, fy8_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v8_reg <= 1'b0;
        else
            v8_reg <= v7_reg;
    end

    always_ff @(posedge clk)
    begin
        ctl8_reg <= ctl7_reg;
        ok8_reg  <= ok7_reg;
        cx0_reg  <= x1;
        cx1_reg  <= xc1;
        cy0_reg  <= y1;
        cy1_reg  <= yc1;
        fx8_reg  <= qx7_reg[15:0];
        fy8_reg  <= qy7_reg[15:0];
    end

    // ---------------- stage 9: texel addresses ----------------
    logic [AW-1:0] row0, row1;

    assign row0 = AW'(AW'(cy0_reg) * AW'(eff_w));
    assign row1 = AW'(AW'(cy1_reg) * AW'(eff_w));

    logic          v9_reg;
    ctl_t          ctl9_reg;
    logic          ok9_reg;
    logic [AW-1:0] addr9_reg [4];
    logic [15:0]   fx9_reg, fy9_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v9_reg <= 1'b0;
        else
            v9_reg <= v8_reg;
    end

    always_ff @(posedge clk)
    begin
        ctl9_reg     <= ctl8_reg;
        ok9_reg      <= ok8_reg;
        addr9_reg[0] <= row0 + AW'(cx0_reg);
        addr9_reg[1] <= row0 + AW'(cx1_reg);
        addr9_reg[2] <= row1 + AW'(cx0_reg);
        addr9_reg[3] <= row1 + AW'(cx1_reg);
        fx9_reg      <= fx8_reg;
        fy9_reg      <= fy8_reg;
    end

    // ---------------- stage 10: mask banks, one copy per corner ----------------
    logic       mask_wr;
    logic [7:0] tex_reg [4];

    assign mask_wr = v9_reg & ctl9_reg.wen;

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [7:0] mem [DEPTH];

        always_ff @(posedge clk)
        begin
            if (mask_wr)
                mem[ctl9_reg.waddr] <= ctl9_reg.lum;
            tex_reg[b] <= mem[addr9_reg[b]];
        end
    end

    logic        v10_reg;
    logic        smp10_reg;
    logic        ok10_reg;
    logic [15:0] fx10_reg, fy10_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v10_reg <= 1'b0;
        else
            v10_reg <= v9_reg;
    end

    always_ff @(posedge clk)
    begin
        smp10_reg <= ctl9_reg.smp;
        ok10_reg  <= ok9_reg;
        fx10_reg  <= fx9_reg;
        fy10_reg  <= fy9_reg;
    end

    // ---------------- stage 11: horizontal blend ----------------
    logic [16:0] wx0, wx1;

    assign wx1 = {1'b0, fx10_reg};
    assign wx0 = 17'h1_0000 - wx1;

    logic        v11_reg;
    logic        smp11_reg;
    logic        ok11_reg;
    logic [24:0] l1_reg, l2_reg;
    logic [15:0] fy11_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v11_reg <= 1'b0;
        else
            v11_reg <= v10_reg;
    end

    always_ff @(posedge clk)
    begin
        smp11_reg <= smp10_reg;
        ok11_reg  <= ok10_reg;
        fy11_reg  <= fy10_reg;
        l1_reg    <= 25'(tex_reg[0]) * 25'(wx0) + 25'(tex_reg[1]) * 25'(wx1);
        l2_reg    <= 25'(tex_reg[2]) * 25'(wx0) + 25'(tex_reg[3]) * 25'(wx1);
    end

    // ---------------- stage 12: vertical blend and result ----------------
    logic [16:0] wy0, wy1;
    logic [41:0] lsum;

    assign wy1  = {1'b0, fy11_reg};
    assign wy0  = 17'h1_0000 - wy1;
    assign lsum = 42'(l1_reg) * 42'(wy0) + 42'(l2_reg) * 42'(wy1);

    logic        done_reg;
    logic [15:0] mask_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v11_reg & smp11_reg;
    end

    always_ff @(posedge clk)
    begin
        mask_value_reg <= ok11_reg ? lsum[39:24] : 16'd0;
    end

    assign done       = done_reg;
    assign mask_value = mask_value_reg;

    // ---------------- checks ----------------
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy && cmd == spm_pkg::CMD_SAMPLE, LAT))
        else $error("result without a matching sample beat");

    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> mask_value <= 16'hFF00)
        else $error("blended value above full scale");

    a_fetch_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        v9_reg && ctl9_reg.smp |-> (32'(addr9_reg[3]) < 32'(DEPTH))
                                && (32'(addr9_reg[0]) < 32'(DEPTH)))
        else $error("texel fetch beyond the mask");

endmodule

// ----- design/spm_div.sv -----
// pipelined restoring divider, one quotient bit per stage, with side tag
module spm_div #(
    parameter int NW = 32,
    parameter int QW = spm_pkg::U_BITS,
    parameter int TW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NW-1:0] in_num,
    input  logic [NW:0]   in_den,
    input  logic [TW-1:0] in_tag,
    output logic          out_valid,
    output logic [QW-1:0] out_quo,
    output logic [TW-1:0] out_tag
);

    localparam int RW = NW + 1;

    logic          val_reg [QW];
    logic [RW-1:0] rem_reg [QW];
    logic [RW-1:0] den_reg [QW];
    logic [QW-1:0] quo_reg [QW];
    logic [TW-1:0] tag_reg [QW];

    for (genvar i = 0; i < QW; i++) begin : g_step
        logic          val_in;
        logic [RW-1:0] rem_in;
        logic [RW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [TW-1:0] tag_in;
        logic [RW:0]   shifted;
        logic [RW:0]   diff;
        logic          ge;

        // stage inputs come from the ports or the stage before
        if (i == 0) begin : g_first
            assign val_in = in_valid;
            assign rem_in = RW'(in_num);
            assign den_in = in_den;
            assign quo_in = '0;
            assign tag_in = in_tag;
        end else begin : g_next
            assign val_in = val_reg[i-1];
            assign rem_in = rem_reg[i-1];
            assign den_in = den_reg[i-1];
            assign quo_in = quo_reg[i-1];
            assign tag_in = tag_reg[i-1];
        end

        // shift in one zero bit and try the subtract
        assign shifted = {rem_in, 1'b0};
        assign diff    = shifted - {1'b0, den_in};
        assign ge      = shifted >= {1'b0, den_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                val_reg[i] <= 1'b0;
            end
            else
            begin
                val_reg[i] <= val_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i] <= ge ? diff[RW-1:0] : shifted[RW-1:0];
            den_reg[i] <= den_in;
            quo_reg[i] <= {quo_in[QW-2:0], ge};
            tag_reg[i] <= tag_in;
        end
    end

    assign out_valid = val_reg[QW-1];
    assign out_quo   = quo_reg[QW-1];
    assign out_tag   = tag_reg[QW-1];

    // a beat leaves once it has passed through all QW stages after entering
    a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(in_valid, QW))
        else $error("divider beat without matching entry");

    // an entering beat is always taken by the first stage
    a_div_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |=> val_reg[0])
        else $error("divider dropped an entering beat");

    // a leaving beat carries a known quotient
    a_div_quo_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown(out_quo))
        else $error("divider quotient unknown on a valid beat");

endmodule

// ----- dv/tb.sv -----
// testbench for the segment plane mask sampler: directed table, then random phases
`timescale 1ns / 1ps

module tb;

    localparam int LIMIT   = 2000;   // quiet cycles before the watchdog fires
    localparam int DRAIN   = 60;     // pipeline latency plus margin
    localparam int N_RAND  = 600;

    typedef struct {
        logic               cmd;
        logic [15:0]        idx;
        logic [7:0]         r, g, b;
        logic               sc;
        logic signed [31:0] sp [3];
        logic signed [31:0] dp [3];
    } beat_t;

    typedef struct {
        beat_t       bt;
        bit          typed;
        logic [15:0] want;
    } dir_row_t;

    logic clk, rst_n;
    logic start, cmd, single_channel;
    logic [15:0] texel_index;
    logic [7:0] red, green, blue;
    logic signed [31:0] src_x, src_y, src_z, dst_x, dst_y, dst_z;
    logic busy, done;
    logic [15:0] mask_value;
    logic psel, penable, pwrite, pready;
    logic [5:0] paddr;
    logic [63:0] pwdata, prdata;

    segment_plane_mask_sampler_top DUT (.*);

    // predictor state: configuration and mask image
    logic [47:0]        mat_row [3];
    logic signed [31:0] offs [3];
    logic [8:0]         side_w, side_h;
    logic [7:0]         mask_img [65536];
    bit                 texel_set [65536];

    logic [15:0] pending_mask [$];
    int          errors;
    int          quiet;
    bit          calm;
    dir_row_t    dir_tbl [$];

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_mask.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, mask_value);
                errors++;
            end
            else
            begin
                logic [15:0] e;
                e = pending_mask.pop_front();
                if (mask_value !== e)
                begin
                    $display("%0t: mask_value mismatch, expected %h, actual %h",
                             $time, e, mask_value);
                    errors++;
                end
            end
        end
    end

    function automatic longint xform(logic [47:0] row, logic signed [31:0] off,
                                     longint x, longint y, longint z);
        longint acc;
        acc = longint'($signed(row[15:0])) * x + longint'($signed(row[31:16])) * y
            + longint'($signed(row[47:32])) * z + longint'(off) * 4096;
        acc = acc >>> 12;
        if (acc > 64'sh7FFF_FFFF) acc = 64'sh7FFF_FFFF;
        if (acc < -64'sh8000_0000) acc = -64'sh8000_0000;
        return acc;
    endfunction

    function automatic longint eff_side(logic [8:0] s);
        if (s == 0) return 1;
        if (s > 256) return 256;
        return s;
    endfunction

    function automatic int unsigned texel_at(longint x, longint y, longint w, longint h);
        if (x >= w) x = w - 1;
        if (y >= h) y = h - 1;
        return int'((x + y * w) % 65536);
    endfunction

    // expected mask value of a sample beat and the four texels it reads
    function automatic logic [15:0] predict_mask(beat_t bt, output bit hit,
                                                 output int unsigned tix [4]);
        longint a [3], c [3];
        longint ma, mb, u, px, py, w, h, qx, qy, x1, y1, fx, fy, l1, l2, l;
        hit = 0;
        for (int k = 0; k < 4; k++) tix[k] = 0;
        for (int k = 0; k < 3; k++)
        begin
            a[k] = xform(mat_row[k], offs[k], bt.sp[0], bt.sp[1], bt.sp[2]);
            c[k] = xform(mat_row[k], offs[k], bt.dp[0], bt.dp[1], bt.dp[2]);
        end
        if (!((a[2] > 0 && c[2] < 0) || (a[2] < 0 && c[2] > 0))) return 16'h0;
        ma = a[2] < 0 ? -a[2] : a[2];
        mb = c[2] < 0 ? -c[2] : c[2];
        u  = (ma << 30) / (ma + mb);
        px = a[0] + (((c[0] - a[0]) * u) >>> 30);
        py = a[1] + (((c[1] - a[1]) * u) >>> 30);
        if (px < -32768 || px >= 32768 || py < -32768 || py >= 32768) return 16'h0;
        w  = eff_side(side_w);
        h  = eff_side(side_h);
        qx = (px + 32768) * (w - 1);
        qy = (py + 32768) * (h - 1);
        x1 = qx >> 16;
        y1 = qy >> 16;
        fx = qx & 16'hFFFF;
        fy = qy & 16'hFFFF;
        tix[0] = texel_at(x1, y1, w, h);
        tix[1] = texel_at(x1 + 1, y1, w, h);
        tix[2] = texel_at(x1, y1 + 1, w, h);
        tix[3] = texel_at(x1 + 1, y1 + 1, w, h);
        hit = 1;
        l1 = longint'(mask_img[tix[0]]) * (65536 - fx) + longint'(mask_img[tix[1]]) * fx;
        l2 = longint'(mask_img[tix[2]]) * (65536 - fx) + longint'(mask_img[tix[3]]) * fx;
        l  = l1 * (65536 - fy) + l2 * fy;
        return 16'((l >> 24) & 16'hFFFF);
    endfunction

    function automatic beat_t mk_write(logic [15:0] idx, logic [7:0] r, logic [7:0] g,
                                       logic [7:0] b, logic sc);
        beat_t bt;
        bt = '{default: '0, sp: '{0, 0, 0}, dp: '{0, 0, 0}};
        bt.cmd = spm_pkg::CMD_WRITE;
        bt.idx = idx;
        bt.r = r;
        bt.g = g;
        bt.b = b;
        bt.sc = sc;
        return bt;
    endfunction

    function automatic beat_t mk_seg(int sx, int sy, int sz, int dx, int dy, int dz);
        beat_t bt;
        bt = '{default: '0, sp: '{0, 0, 0}, dp: '{0, 0, 0}};
        bt.cmd = spm_pkg::CMD_SAMPLE;
        bt.sp[0] = sx; bt.sp[1] = sy; bt.sp[2] = sz;
        bt.dp[0] = dx; bt.dp[1] = dy; bt.dp[2] = dz;
        return bt;
    endfunction

    // random idle cycle ahead of a beat
    task automatic maybe_idle();
        if (!calm && $urandom_range(99) < 30)
        begin
            start = 1'b0;
            @(negedge clk);
        end
    endtask

    // drive one beat until accepted, then update the model
    task automatic send_beat(beat_t bt, bit has_res, logic [15:0] want);
        maybe_idle();
        cmd = bt.cmd;
        texel_index = bt.idx;
        red = bt.r;
        green = bt.g;
        blue = bt.b;
        single_channel = bt.sc;
        src_x = bt.sp[0]; src_y = bt.sp[1]; src_z = bt.sp[2];
        dst_x = bt.dp[0]; dst_y = bt.dp[1]; dst_z = bt.dp[2];
        start = 1'b1;
        do @(posedge clk); while (busy);
        if (bt.cmd == spm_pkg::CMD_WRITE)
        begin
            mask_img[bt.idx] = bt.sc ? bt.r : 8'((int'(bt.r) + bt.g + bt.b) / 3);
            texel_set[bt.idx] = 1'b1;
        end
        else if (has_res)
            pending_mask.push_back(want);
        @(negedge clk);
    endtask

    // sample beat: fill any texel it would read that was never written
    task automatic run_sample(beat_t bt, bit typed, logic [15:0] want);
        bit hit;
        int unsigned tix [4];
        logic [15:0] val;
        val = predict_mask(bt, hit, tix);
        if (hit)
            for (int k = 0; k < 4; k++)
                if (!texel_set[tix[k]])
                    send_beat(mk_write(16'(tix[k]), 8'($urandom), 8'($urandom),
                                       8'($urandom), 1'($urandom)), 0, '0);
        val = predict_mask(bt, hit, tix);
        send_beat(bt, 1, typed ? want : val);
    endtask

    task automatic run_beat(beat_t bt, bit typed, logic [15:0] want);
        if (bt.cmd == spm_pkg::CMD_SAMPLE)
            run_sample(bt, typed, want);
        else
            send_beat(bt, 0, '0);
    endtask

    task automatic write_reg(spm_pkg::reg_idx_t ri, logic [63:0] val);
        start = 1'b0;
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {ri, 3'b000};
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        case (ri)
            spm_pkg::REG_ROW_X:       mat_row[0] = val[47:0];
            spm_pkg::REG_ROW_Y:       mat_row[1] = val[47:0];
            spm_pkg::REG_ROW_Z:       mat_row[2] = val[47:0];
            spm_pkg::REG_OFFSET_X:    offs[0] = val[31:0];
            spm_pkg::REG_OFFSET_Y:    offs[1] = val[31:0];
            spm_pkg::REG_OFFSET_Z:    offs[2] = val[31:0];
            spm_pkg::REG_MASK_WIDTH:  side_w = val[8:0];
            spm_pkg::REG_MASK_HEIGHT: side_h = val[8:0];
            default: ;
        endcase
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // wait for outstanding results, then let the pipeline empty
    task automatic drain();
        start = 1'b0;
        while (pending_mask.size() != 0) @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    function automatic logic [15:0] rcoef(int center, int spread);
        return 16'(center + $signed($urandom_range(2 * spread)) - spread);
    endfunction

    // one configuration per phase, extremes first
    task automatic set_phase(int kind);
        logic [15:0] c [3][3];
        drain();
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                c[i][j] = (i == j) ? 16'h1000 : 16'h0000;
        case (kind)
            0: ;
            1:
            begin
                write_reg(spm_pkg::REG_MASK_WIDTH, 64'd1);
                write_reg(spm_pkg::REG_MASK_HEIGHT, 64'd1);
            end
            2:
            begin
                write_reg(spm_pkg::REG_MASK_WIDTH, 64'd0);
                write_reg(spm_pkg::REG_MASK_HEIGHT, 64'd511);
            end
            3:
            begin
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++)
                        c[i][j] = (i == j) ? rcoef(4096, 512) : rcoef(0, 256);
                write_reg(spm_pkg::REG_OFFSET_X,
                          64'(32'($signed($urandom_range(8000)) - 4000)));
                write_reg(spm_pkg::REG_OFFSET_Y,
                          64'(32'($signed($urandom_range(8000)) - 4000)));
                write_reg(spm_pkg::REG_OFFSET_Z,
                          64'(32'($signed($urandom_range(8000)) - 4000)));
                write_reg(spm_pkg::REG_MASK_WIDTH, 64'($urandom_range(2, 20)));
                write_reg(spm_pkg::REG_MASK_HEIGHT, 64'($urandom_range(2, 20)));
            end
            4:
            begin
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++)
                        c[i][j] = $urandom_range(1) ? 16'h7FFF : 16'h8000;
                write_reg(spm_pkg::REG_OFFSET_X, 64'h7FFF_FFFF);
                write_reg(spm_pkg::REG_OFFSET_Y, 64'h8000_0000);
                write_reg(spm_pkg::REG_OFFSET_Z, 64'(32'($urandom)));
                write_reg(spm_pkg::REG_MASK_WIDTH, 64'd256);
                write_reg(spm_pkg::REG_MASK_HEIGHT, 64'd256);
            end
            default:
            begin
                // swapped and mirrored axes
                c[0][0] = 16'h0; c[0][1] = 16'hF000;
                c[1][1] = 16'h0; c[1][0] = 16'h1000;
                write_reg(spm_pkg::REG_OFFSET_X, 64'd0);
                write_reg(spm_pkg::REG_OFFSET_Y, 64'd0);
                write_reg(spm_pkg::REG_OFFSET_Z, 64'd0);
                write_reg(spm_pkg::REG_MASK_WIDTH, 64'($urandom_range(2, 256)));
                write_reg(spm_pkg::REG_MASK_HEIGHT, 64'($urandom_range(2, 9)));
            end
        endcase
        write_reg(spm_pkg::REG_ROW_X, {16'h0, c[0][2], c[0][1], c[0][0]});
        write_reg(spm_pkg::REG_ROW_Y, {16'h0, c[1][2], c[1][1], c[1][0]});
        write_reg(spm_pkg::REG_ROW_Z, {16'h0, c[2][2], c[2][1], c[2][0]});
    endtask

    // texel write, segment crossing the plane near the unit square, or pure noise
    function automatic beat_t rand_beat();
        beat_t bt;
        int tx, ty, ox, oy, z1, z2;
        int sel;
        sel = $urandom_range(99);
        if (sel < 25)
            return mk_write(16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                            1'($urandom));
        if (sel < 35)
        begin
            bt = mk_seg($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            return bt;
        end
        tx = $signed($urandom_range(70000)) - 35000;
        ty = $signed($urandom_range(70000)) - 35000;
        ox = $signed($urandom_range(4000)) - 2000;
        oy = $signed($urandom_range(4000)) - 2000;
        z1 = $urandom_range(1, 1 << 20);
        z2 = -$signed($urandom_range(0, 1 << 20));
        if (sel < 40) z2 = $urandom_range(0, 3) - 1;
        if ($urandom_range(1))
            return mk_seg(tx + ox, ty + oy, z1, tx - ox, ty - oy, z2);
        return mk_seg(tx - ox, ty - oy, z2, tx + ox, ty + oy, z1);
    endfunction

    task automatic build_table();
        dir_row_t row;
        row.typed = 0;
        row.want = '0;
        row.bt = mk_write(16'd0, 8'hFF, 8'hFF, 8'hFF, 1'b0); dir_tbl.push_back(row);
        row.bt = mk_write(16'hFFFF, 8'h00, 8'h00, 8'h00, 1'b0); dir_tbl.push_back(row);
        row.bt = mk_write(16'd1, 8'd200, 8'd7, 8'd9, 1'b1); dir_tbl.push_back(row);
        row.bt = mk_write(16'd2, 8'd254, 8'hFF, 8'hFF, 1'b0); dir_tbl.push_back(row);
        // both ends above, both below, one end on the plane: all rejected
        row.typed = 1;
        row.bt = mk_seg(0, 0, 65536, 0, 0, 131072); dir_tbl.push_back(row);
        row.bt = mk_seg(0, 0, -65536, 0, 0, -1); dir_tbl.push_back(row);
        row.bt = mk_seg(0, 0, 0, 0, 0, -65536); dir_tbl.push_back(row);
        // crossing exactly on the upper x or y bound is outside
        row.bt = mk_seg(32768, 0, 65536, 32768, 0, -65536); dir_tbl.push_back(row);
        row.bt = mk_seg(0, 32768, 65536, 0, 32768, -65536); dir_tbl.push_back(row);
        row.typed = 0;
        row.bt = mk_seg(0, 0, 65536, 0, 0, -65536); dir_tbl.push_back(row);
        row.bt = mk_seg(-32768, -32768, 1, -32768, -32768, -1); dir_tbl.push_back(row);
        row.bt = mk_seg(32767, 32767, 5, 32767, 32767, -7); dir_tbl.push_back(row);
        row.bt = mk_seg(-40000, 20000, 1, 40000, -20000, 32'h8000_0000); dir_tbl.push_back(row);
        row.bt = mk_seg(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000); dir_tbl.push_back(row);
        row.bt = mk_seg(-100, 100, -3, 300, -300, 65536); dir_tbl.push_back(row);
    endtask

    // stimulus
    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = spm_pkg::CMD_WRITE;
        texel_index = '0;
        red = '0; green = '0; blue = '0;
        single_channel = 1'b0;
        src_x = '0; src_y = '0; src_z = '0;
        dst_x = '0; dst_y = '0; dst_z = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        paddr = '0; pwdata = '0;
        errors = 0;
        quiet = 0;
        calm = 0;
        mat_row[0] = spm_pkg::ROW_X_RESET;
        mat_row[1] = spm_pkg::ROW_Y_RESET;
        mat_row[2] = spm_pkg::ROW_Z_RESET;
        offs[0] = 0; offs[1] = 0; offs[2] = 0;
        side_w = spm_pkg::SIZE_RESET; side_h = spm_pkg::SIZE_RESET;
        for (int i = 0; i < 65536; i++)
        begin
            mask_img[i] = '0;
            texel_set[i] = 1'b0;
        end
        build_table();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part under the reset configuration
        foreach (dir_tbl[i])
            run_beat(dir_tbl[i].bt, dir_tbl[i].typed, dir_tbl[i].want);

        // random phases, extreme settings first
        for (int n = 0; n < N_RAND; n++)
        begin
            if (n % 60 == 0)
                set_phase(n < 360 ? n / 60 : $urandom_range(5));
            calm = (n >= 200 && n < 320);
            run_beat(rand_beat(), 0, '0);
        end

        drain();
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
